// File: design/dlst_pkg.sv
// Shared types, constants and arithmetic helpers for the dense layer trainer.
// Used by dlst_ram, dlst_ctrl, dlst_dp and dense_layer_sigmoid_trainer.
// No dependencies.
package dlst_pkg;

	localparam int DEF_MAX_INPUTS  = 64;
	localparam int DEF_MAX_OUTPUTS = 64;

	localparam int DW       = 16;   // Q4.12 data word
	localparam int FRAC     = 12;
	localparam int IDX_W    = 6;
	localparam int CMD_W    = 3;
	localparam int CNT_W    = 7;
	localparam int RATE_W   = 15;
	localparam int CFG_W    = 15;
	localparam int CFG_IDX_W = 2;

	localparam int ONE_Q       = 4096;
	localparam int SIG_SAT     = 20480;
	localparam int SIG_KNEE    = 9728;
	localparam int SIG_HI_OFS  = 3456;
	localparam int SIG_MID_OFS = 2560;
	localparam int SIG_LO_OFS  = 2048;

	// Correction arithmetic
	localparam int ACT_W      = 13;             // stored activations lie in 0..1.0
	localparam int D_W        = 11;             // out*(1-out), at most 0.25
	localparam int PE_W       = 32;
	localparam int F_W        = 44;
	localparam int SPLIT      = 22;
	localparam int PROD_W     = 60;
	localparam int CORR_SHIFT = 36;
	localparam int DELTA_W    = PROD_W - CORR_SHIFT;

	localparam logic [CNT_W-1:0]  RST_INPUTS  = 7'd64;
	localparam logic [CNT_W-1:0]  RST_OUTPUTS = 7'd64;
	localparam logic [RATE_W-1:0] RST_RATE    = 15'd410;

	typedef enum logic [CMD_W-1:0] {
		CMD_WEIGHT  = 3'd0,
		CMD_BIAS    = 3'd1,
		CMD_ACT     = 3'd2,
		CMD_ERR     = 3'd3,
		CMD_FORWARD = 3'd4,
		CMD_BACKWARD = 3'd5,
		CMD_CORRECT = 3'd6
	} cmd_t;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_INPUTS  = 2'd0,
		REG_OUTPUTS = 2'd1,
		REG_RATE    = 2'd2
	} reg_idx_t;

	typedef enum logic [1:0] {
		KIND_ACT  = 2'd0,
		KIND_ERR  = 2'd1,
		KIND_DONE = 2'd2
	} kind_t;

	typedef enum logic [1:0] {
		OP_FWD  = 2'd0,
		OP_BWD  = 2'd1,
		OP_CORR = 2'd2
	} op_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_HEAD,
		ST_HWAIT,
		ST_RUN,
		ST_DRAIN,
		ST_EMIT,
		ST_DONE
	} state_t;

	// Command from controller to datapath, one per cycle
	typedef struct packed {
		logic             mac;
		logic             first;
		logic             head;
		op_t              op;
		logic             emit;
		kind_t            kind;
		logic             last;
		logic [IDX_W-1:0] index;
	} dp_ctl_t;

	function automatic int aw(input int depth);
		return (depth > 1) ? $clog2(depth) : 1;
	endfunction

	function automatic int imax(input int a, input int b);
		return (a > b) ? a : b;
	endfunction

	// Piecewise linear sigmoid in Q4.12
	function automatic logic signed [DW-1:0] sigmoid_q(input logic signed [DW-1:0] x);
		logic [DW:0] a;
		logic [DW:0] y;
		a = x[DW-1] ? ((~{x[DW-1], x}) + 1'b1) : {x[DW-1], x};
		if (a >= (DW+1)'(SIG_SAT))
			y = (DW+1)'(ONE_Q);
		else if (a >= (DW+1)'(SIG_KNEE))
			y = (a >> 5) + (DW+1)'(SIG_HI_OFS);
		else if (a >= (DW+1)'(ONE_Q))
			y = (a >> 3) + (DW+1)'(SIG_MID_OFS);
		else
			y = (a >> 2) + (DW+1)'(SIG_LO_OFS);
		return x[DW-1] ? DW'((DW+1)'(ONE_Q) - y) : DW'(y);
	endfunction

endpackage

// File: design/dlst_ram.sv
// Generic simple dual-port RAM: one write port, one registered read port.
// Uses dlst_pkg for the address width helper.
module dlst_ram #(
	parameter int WIDTH = dlst_pkg::DW,
	parameter int DEPTH = dlst_pkg::DEF_MAX_INPUTS
) (
	input  logic                               clk,
	input  logic                               we,
	input  logic [dlst_pkg::aw(DEPTH)-1:0]     waddr,
	input  logic [WIDTH-1:0]                   wdata,
	input  logic [dlst_pkg::aw(DEPTH)-1:0]     raddr,
	output logic [WIDTH-1:0]                   rdata
);
	import dlst_pkg::*;

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we)
			mem_q[waddr] <= wdata;
		rdata <= mem_q[raddr];
	end

endmodule

// File: design/dlst_ctrl.sv
// Sequencer for forward, backward and correct passes over the weight matrix.
// Drives the datapath command struct and store addresses; uses dlst_pkg.
module dlst_ctrl #(
	parameter int MAX_INPUTS  = dlst_pkg::DEF_MAX_INPUTS,
	parameter int MAX_OUTPUTS = dlst_pkg::DEF_MAX_OUTPUTS
) (
	input  logic                                           clk,
	input  logic                                           arst_n,
	input  logic                                           in_accept,
	input  dlst_pkg::cmd_t                                 in_cmd,
	input  logic [dlst_pkg::aw(MAX_INPUTS)-1:0]            ni_last,
	input  logic [dlst_pkg::aw(MAX_OUTPUTS)-1:0]           no_last,
	input  logic                                           out_free,
	output logic                                           in_ready,
	output dlst_pkg::dp_ctl_t                              ctl,
	output logic [dlst_pkg::aw(MAX_OUTPUTS*MAX_INPUTS)-1:0] w_addr,
	output logic [dlst_pkg::aw(MAX_OUTPUTS)-1:0]           o_addr,
	output logic [dlst_pkg::aw(MAX_INPUTS)-1:0]            i_addr
);
	import dlst_pkg::*;

	localparam int IW  = aw(MAX_INPUTS);
	localparam int OW  = aw(MAX_OUTPUTS);
	localparam int CW  = imax(IW, OW);
	localparam int WAW = aw(MAX_OUTPUTS * MAX_INPUTS);

	state_t           state_q, state_d;
	op_t              op_q;
	logic [CW-1:0]    outer_q, inner_q;
	logic [WAW-1:0]   base_q, waddr_q;
	logic [1:0]       wait_q;
	logic             inner_last, outer_last;
	logic [WAW-1:0]   step_in, step_out;

	assign inner_last = (op_q == OP_BWD) ? (inner_q == CW'(no_last)) : (inner_q == CW'(ni_last));
	assign outer_last = (op_q == OP_BWD) ? (outer_q == CW'(ni_last)) : (outer_q == CW'(no_last));
	assign step_in    = (op_q == OP_BWD) ? WAW'(MAX_INPUTS) : WAW'(1);
	assign step_out   = (op_q == OP_BWD) ? WAW'(1) : WAW'(MAX_INPUTS);

	assign o_addr = (op_q == OP_BWD) ? OW'(inner_q) : OW'(outer_q);
	assign i_addr = (op_q == OP_BWD) ? IW'(outer_q) : IW'(inner_q);
	assign w_addr = waddr_q;

	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE: begin
				if (in_accept) begin
					case (in_cmd)
						CMD_FORWARD, CMD_BACKWARD: state_d = ST_RUN;
						CMD_CORRECT:               state_d = ST_HEAD;
						default:                   state_d = ST_IDLE;
					endcase
				end
			end
			ST_HEAD:  state_d = ST_HWAIT;
			ST_HWAIT: begin
				if (wait_q == 2'd0)
					state_d = ST_RUN;
			end
			ST_RUN: begin
				if (inner_last)
					state_d = (op_q == OP_CORR && !outer_last) ? ST_HEAD : ST_DRAIN;
			end
			ST_DRAIN: begin
				if (wait_q == 2'd0)
					state_d = (op_q == OP_CORR) ? ST_DONE : ST_EMIT;
			end
			ST_EMIT: begin
				if (out_free)
					state_d = outer_last ? ST_IDLE : ST_RUN;
			end
			ST_DONE: begin
				if (out_free)
					state_d = ST_IDLE;
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_comb begin
		ctl       = '0;
		ctl.op    = op_q;
		in_ready  = 1'b0;
		case (state_q)
			ST_IDLE: in_ready = 1'b1;
			ST_HEAD: ctl.head = 1'b1;
			ST_RUN: begin
				ctl.mac   = 1'b1;
				ctl.first = (inner_q == '0);
			end
			ST_EMIT: begin
				ctl.emit  = out_free;
				ctl.kind  = (op_q == OP_FWD) ? KIND_ACT : KIND_ERR;
				ctl.last  = outer_last;
				ctl.index = IDX_W'(outer_q);
			end
			ST_DONE: begin
				ctl.emit = out_free;
				ctl.kind = KIND_DONE;
				ctl.last = 1'b1;
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			op_q    <= OP_FWD;
			outer_q <= '0;
			inner_q <= '0;
			base_q  <= '0;
			waddr_q <= '0;
			wait_q  <= '0;
		end else begin
			state_q <= state_d;
			case (state_q)
				ST_IDLE: begin
					outer_q <= '0;
					inner_q <= '0;
					base_q  <= '0;
					waddr_q <= '0;
					if (in_accept) begin
						case (in_cmd)
							CMD_FORWARD:  op_q <= OP_FWD;
							CMD_BACKWARD: op_q <= OP_BWD;
							CMD_CORRECT:  op_q <= OP_CORR;
							default:      op_q <= op_q;
						endcase
					end
				end
				ST_HEAD: wait_q <= 2'd1;
				ST_HWAIT, ST_DRAIN: begin
					if (wait_q != 2'd0)
						wait_q <= wait_q - 2'd1;
				end
				ST_RUN: begin
					if (inner_last) begin
						inner_q <= '0;
						wait_q  <= 2'd2;
						if (op_q == OP_CORR && !outer_last) begin
							outer_q <= outer_q + 1'b1;
							base_q  <= base_q + step_out;
							waddr_q <= base_q + step_out;
						end
					end else begin
						inner_q <= inner_q + 1'b1;
						waddr_q <= waddr_q + step_in;
					end
				end
				ST_EMIT: begin
					if (out_free && !outer_last) begin
						outer_q <= outer_q + 1'b1;
						base_q  <= base_q + step_out;
						waddr_q <= base_q + step_out;
					end
				end
				default: ;
			endcase
		end
	end

endmodule

// File: design/dlst_dp.sv
// Datapath: the five stores, multiply-accumulate and correction pipelines,
// sigmoid and the output register. Depends on dlst_pkg and dlst_ram.
module dlst_dp #(
	parameter int MAX_INPUTS  = dlst_pkg::DEF_MAX_INPUTS,
	parameter int MAX_OUTPUTS = dlst_pkg::DEF_MAX_OUTPUTS
) (
	input  logic                                           clk,
	input  logic                                           arst_n,
	input  logic                                           ld_en,
	input  dlst_pkg::cmd_t                                 ld_cmd,
	input  logic [dlst_pkg::IDX_W-1:0]                     ld_out_index,
	input  logic [dlst_pkg::IDX_W-1:0]                     ld_in_index,
	input  logic signed [dlst_pkg::DW-1:0]                 ld_value,
	input  logic [dlst_pkg::RATE_W-1:0]                    rate,
	input  dlst_pkg::dp_ctl_t                              ctl,
	input  logic [dlst_pkg::aw(MAX_OUTPUTS*MAX_INPUTS)-1:0] w_addr,
	input  logic [dlst_pkg::aw(MAX_OUTPUTS)-1:0]           o_addr,
	input  logic [dlst_pkg::aw(MAX_INPUTS)-1:0]            i_addr,
	output logic                                           out_free,
	output logic                                           out_valid,
	input  logic                                           out_ready,
	output dlst_pkg::kind_t                                out_kind,
	output logic [dlst_pkg::IDX_W-1:0]                     out_index,
	output logic signed [dlst_pkg::DW-1:0]                 out_value,
	output logic                                           out_last
);
	import dlst_pkg::*;

	localparam int IW    = aw(MAX_INPUTS);
	localparam int OW    = aw(MAX_OUTPUTS);
	localparam int WAW   = aw(MAX_OUTPUTS * MAX_INPUTS);
	localparam int ACC_W = 2 * DW + aw(imax(MAX_INPUTS, MAX_OUTPUTS)) + 2;
	localparam int SUM_W = DELTA_W + 1;

	typedef struct packed {
		logic mac;
		logic first;
		logic head;
		op_t  op;
	} tag_t;

	// Store read data
	logic signed [DW-1:0] w_rd, bias_rd, in_rd, err_rd, oact_rd;

	// Store write ports
	logic                 w_we, bias_we, in_we, err_we, oact_we;
	logic [WAW-1:0]       w_waddr;
	logic signed [DW-1:0] w_wdata;
	logic [MAX_OUTPUTS-1:0] oact_vld_q;

	// Pipeline
	tag_t                     tag_s1, tag_s2;
	logic [WAW-1:0]           waddr_s1, waddr_s2, waddr_s3;
	logic                     vld_s1;
	logic signed [2*DW-1:0]   prod_s2;
	logic signed [DW-1:0]     bias_s2, w_s2, w_s3;
	logic [2*ACT_W-1:0]       dprod_s2;
	logic signed [PE_W-1:0]   pe_s2;
	logic signed [SPLIT+DW-1:0]   pphi_s2;
	logic signed [SPLIT+DW:0]     pplo_s2;
	logic signed [DELTA_W-1:0]    delta_s3;
	logic                         wr_s3;
	logic signed [ACC_W-1:0]  acc_q;
	logic signed [F_W-1:0]    f_q;

	logic signed [DW-1:0]     mac_a;
	logic [ACT_W-1:0]         a13;
	logic signed [F_W-SPLIT-1:0] f_hi;
	logic [SPLIT-1:0]         f_lo;
	logic signed [ACC_W-1:0]  bias_ext, acc_base, acc_sh;
	logic signed [PROD_W-1:0] corr_prod;
	logic signed [SUM_W-1:0]  wsum;
	logic signed [DW-1:0]     wsat, acc_sat, emit_val;
	logic                     ld_o_ok, ld_i_ok;

	assign ld_o_ok = int'(ld_out_index) < MAX_OUTPUTS;
	assign ld_i_ok = int'(ld_in_index) < MAX_INPUTS;

	assign w_we    = wr_s3 || (ld_en && ld_cmd == CMD_WEIGHT && ld_o_ok && ld_i_ok);
	assign w_waddr = wr_s3 ? waddr_s3
	                       : WAW'(int'(ld_out_index) * MAX_INPUTS + int'(ld_in_index));
	assign w_wdata = wr_s3 ? wsat : ld_value;
	assign bias_we = ld_en && ld_cmd == CMD_BIAS && ld_o_ok;
	assign in_we   = ld_en && ld_cmd == CMD_ACT && ld_i_ok;
	assign err_we  = ld_en && ld_cmd == CMD_ERR && ld_o_ok;
	assign oact_we = ctl.emit && ctl.kind == KIND_ACT;

	dlst_ram #(.WIDTH(DW), .DEPTH(MAX_OUTPUTS * MAX_INPUTS)) u_weight (
		.clk(clk), .we(w_we), .waddr(w_waddr), .wdata(w_wdata),
		.raddr(w_addr), .rdata(w_rd)
	);

	dlst_ram #(.WIDTH(DW), .DEPTH(MAX_OUTPUTS)) u_bias (
		.clk(clk), .we(bias_we), .waddr(OW'(ld_out_index)), .wdata(ld_value),
		.raddr(o_addr), .rdata(bias_rd)
	);

	dlst_ram #(.WIDTH(DW), .DEPTH(MAX_INPUTS)) u_in_act (
		.clk(clk), .we(in_we), .waddr(IW'(ld_in_index)), .wdata(ld_value),
		.raddr(i_addr), .rdata(in_rd)
	);

	dlst_ram #(.WIDTH(DW), .DEPTH(MAX_OUTPUTS)) u_err (
		.clk(clk), .we(err_we), .waddr(OW'(ld_out_index)), .wdata(ld_value),
		.raddr(o_addr), .rdata(err_rd)
	);

	dlst_ram #(.WIDTH(DW), .DEPTH(MAX_OUTPUTS)) u_out_act (
		.clk(clk), .we(oact_we), .waddr(o_addr), .wdata(emit_val),
		.raddr(o_addr), .rdata(oact_rd)
	);

	// Stage 1: store data valid, form products
	assign mac_a = (tag_s1.op == OP_BWD) ? err_rd : in_rd;
	// Activations come only from the sigmoid, so 13 bits hold them
	assign a13   = vld_s1 ? oact_rd[ACT_W-1:0] : '0;
	assign f_hi  = f_q[F_W-1:SPLIT];
	assign f_lo  = f_q[SPLIT-1:0];

	// Stage 2 helpers
	assign bias_ext  = ACC_W'(bias_s2);
	assign acc_base  = (tag_s2.op == OP_FWD) ? (bias_ext <<< FRAC) : '0;
	assign corr_prod = (PROD_W'(pphi_s2) <<< SPLIT) + PROD_W'(pplo_s2);

	// Stage 3: saturating weight update
	assign wsum = SUM_W'(w_s3) + SUM_W'(delta_s3);
	always_comb begin
		if ((&wsum[SUM_W-1:DW-1]) || !(|wsum[SUM_W-1:DW-1]))
			wsat = wsum[DW-1:0];
		else
			wsat = wsum[SUM_W-1] ? {1'b1, {(DW-1){1'b0}}} : {1'b0, {(DW-1){1'b1}}};
	end

	// Result: floor shift and saturate
	assign acc_sh = acc_q >>> FRAC;
	always_comb begin
		if ((&acc_sh[ACC_W-1:DW-1]) || !(|acc_sh[ACC_W-1:DW-1]))
			acc_sat = acc_sh[DW-1:0];
		else
			acc_sat = acc_sh[ACC_W-1] ? {1'b1, {(DW-1){1'b0}}} : {1'b0, {(DW-1){1'b1}}};
	end

	always_comb begin
		case (ctl.kind)
			KIND_ACT: emit_val = sigmoid_q(acc_sat);
			KIND_ERR: emit_val = acc_sat;
			default:  emit_val = '0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tag_s1     <= '0;
			tag_s2     <= '0;
			wr_s3      <= 1'b0;
			oact_vld_q <= '0;
			out_valid  <= 1'b0;
		end else begin
			tag_s1 <= '{mac: ctl.mac, first: ctl.first, head: ctl.head, op: ctl.op};
			tag_s2 <= tag_s1;
			wr_s3  <= tag_s2.mac && tag_s2.op == OP_CORR;
			if (oact_we)
				oact_vld_q[o_addr] <= 1'b1;
			if (ctl.emit)
				out_valid <= 1'b1;
			else if (out_ready)
				out_valid <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		waddr_s1 <= w_addr;
		vld_s1   <= oact_vld_q[o_addr];

		prod_s2  <= mac_a * w_rd;
		bias_s2  <= bias_rd;
		dprod_s2 <= a13 * (ACT_W'(ONE_Q) - a13);
		pe_s2    <= $signed({1'b0, rate}) * err_rd;
		pphi_s2  <= f_hi * in_rd;
		pplo_s2  <= $signed({1'b0, f_lo}) * in_rd;
		w_s2     <= w_rd;
		waddr_s2 <= waddr_s1;

		if (tag_s2.mac && tag_s2.op != OP_CORR)
			acc_q <= (tag_s2.first ? acc_base : acc_q) + ACC_W'(prod_s2);
		if (tag_s2.head)
			f_q <= pe_s2 * $signed({1'b0, dprod_s2[FRAC+D_W-1:FRAC]});
		delta_s3 <= corr_prod[PROD_W-1:CORR_SHIFT];
		w_s3     <= w_s2;
		waddr_s3 <= waddr_s2;

		if (ctl.emit) begin
			out_kind  <= ctl.kind;
			out_index <= ctl.index;
			out_value <= emit_val;
			out_last  <= ctl.last;
		end
	end

	assign out_free = !out_valid || out_ready;

endmodule

// File: design/dense_layer_sigmoid_trainer.sv
// Dense layer with sigmoid outputs and on-chip weight correction.
// Top level: configuration registers, stream ports, dlst_ctrl and dlst_dp.
//
// Usage
//   s_axis carries commands: tuser = command, tdata = out_index, in_index,
//   value. Load commands (weight, bias, input activation, output error)
//   write one store entry and produce nothing. Forward emits one activation
//   per output neuron, backward one error per input, correct updates every
//   weight in use and emits one done transaction. m_axis tlast marks the
//   final transaction of a command.
//   cfg writes the input count, output count and learning rate; write them
//   only while no command is in progress.
// Timing
//   One weight is read per cycle while a row is swept; a stalled m_axis
//   holds the sequencer before the next row. A new command is accepted
//   only after the previous one has finished.
// Reset
//   Counts return to 64, learning rate to 410; output activations read as
//   zero until the first forward pass. A stalled m_axis holds its
//   transaction and the sequencer waits before the next result.
module dense_layer_sigmoid_trainer #(
	parameter int MAX_INPUTS  = dlst_pkg::DEF_MAX_INPUTS,
	parameter int MAX_OUTPUTS = dlst_pkg::DEF_MAX_OUTPUTS
) (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               s_axis_tvalid,
	output logic                               s_axis_tready,
	input  logic [31:0]                        s_axis_tdata,  // out_index, in_index, value, pad
	input  logic [dlst_pkg::CMD_W-1:0]         s_axis_tuser,  // command
	output logic                               m_axis_tvalid,
	input  logic                               m_axis_tready,
	output logic [23:0]                        m_axis_tdata,  // index, result_value, pad
	output logic [1:0]                         m_axis_tuser,  // kind
	output logic                               m_axis_tlast,
	input  logic                               cfg_valid,
	output logic                               cfg_ready,
	input  logic [dlst_pkg::CFG_IDX_W-1:0]     cfg_index,
	input  logic [dlst_pkg::CFG_W-1:0]         cfg_data
);
	import dlst_pkg::*;

	localparam int IW  = aw(MAX_INPUTS);
	localparam int OW  = aw(MAX_OUTPUTS);
	localparam int WAW = aw(MAX_OUTPUTS * MAX_INPUTS);
	localparam int EWI = imax(CNT_W, $clog2(MAX_INPUTS + 1));
	localparam int EWO = imax(CNT_W, $clog2(MAX_OUTPUTS + 1));

	logic [CNT_W-1:0]  inputs_q, outputs_q;
	logic [RATE_W-1:0] rate_q;
	logic [EWI-1:0]    ni_ext;
	logic [EWO-1:0]    no_ext;
	logic [IW-1:0]     ni_last;
	logic [OW-1:0]     no_last;

	logic              in_accept;
	cmd_t              in_cmd;
	dp_ctl_t           ctl;
	logic [WAW-1:0]    w_addr;
	logic [OW-1:0]     o_addr;
	logic [IW-1:0]     i_addr;
	logic              out_free;
	kind_t             out_kind;
	logic [IDX_W-1:0]  out_index;
	logic signed [DW-1:0] out_value;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			inputs_q  <= RST_INPUTS;
			outputs_q <= RST_OUTPUTS;
			rate_q    <= RST_RATE;
		end else if (cfg_valid) begin
			case (reg_idx_t'(cfg_index))
				REG_INPUTS:  inputs_q  <= cfg_data[CNT_W-1:0];
				REG_OUTPUTS: outputs_q <= cfg_data[CNT_W-1:0];
				REG_RATE:    rate_q    <= cfg_data[RATE_W-1:0];
				default: ;
			endcase
		end
	end

	// Zero count acts as one, oversize as the maximum
	assign ni_ext  = EWI'(inputs_q);
	assign no_ext  = EWO'(outputs_q);
	assign ni_last = (inputs_q == '0) ? '0
	               : (ni_ext > EWI'(MAX_INPUTS)) ? IW'(MAX_INPUTS - 1) : IW'(ni_ext - 1'b1);
	assign no_last = (outputs_q == '0) ? '0
	               : (no_ext > EWO'(MAX_OUTPUTS)) ? OW'(MAX_OUTPUTS - 1) : OW'(no_ext - 1'b1);

	assign in_accept = s_axis_tvalid && s_axis_tready;
	assign in_cmd    = cmd_t'(s_axis_tuser);

	dlst_ctrl #(.MAX_INPUTS(MAX_INPUTS), .MAX_OUTPUTS(MAX_OUTPUTS)) u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_accept (in_accept),
		.in_cmd    (in_cmd),
		.ni_last   (ni_last),
		.no_last   (no_last),
		.out_free  (out_free),
		.in_ready  (s_axis_tready),
		.ctl       (ctl),
		.w_addr    (w_addr),
		.o_addr    (o_addr),
		.i_addr    (i_addr)
	);

	dlst_dp #(.MAX_INPUTS(MAX_INPUTS), .MAX_OUTPUTS(MAX_OUTPUTS)) u_dp (
		.clk          (clk),
		.arst_n       (arst_n),
		.ld_en        (in_accept),
		.ld_cmd       (in_cmd),
		.ld_out_index (s_axis_tdata[5:0]),
		.ld_in_index  (s_axis_tdata[11:6]),
		.ld_value     (s_axis_tdata[27:12]),
		.rate         (rate_q),
		.ctl          (ctl),
		.w_addr       (w_addr),
		.o_addr       (o_addr),
		.i_addr       (i_addr),
		.out_free     (out_free),
		.out_valid    (m_axis_tvalid),
		.out_ready    (m_axis_tready),
		.out_kind     (out_kind),
		.out_index    (out_index),
		.out_value    (out_value),
		.out_last     (m_axis_tlast)
	);

	assign m_axis_tuser = out_kind;
	assign m_axis_tdata = {2'b00, out_value, out_index};

endmodule

// File: test/dlst_checker.sv
`timescale 1ns / 100ps
// Checker for the dense layer trainer: watches the command, result and register channels.
// Keeps its own copy of the stores and registers and compares every result; uses dlst_pkg.
module dlst_checker (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_valid,
	input  logic        s_ready,
	input  logic [31:0] s_data,   // out_index, in_index, value, pad
	input  logic [2:0]  s_user,   // command
	input  logic        m_valid,
	input  logic        m_ready,
	input  logic [23:0] m_data,   // index, result_value, pad
	input  logic [1:0]  m_user,   // kind
	input  logic        m_last,
	input  logic        cfg_valid,
	input  logic        cfg_ready,
	input  logic [1:0]  cfg_index,
	input  logic [14:0] cfg_data,
	output int          errors,
	output int          pending
);
	import dlst_pkg::*;

	typedef struct {
		kind_t             kind;
		logic [5:0]        index;
		logic signed [15:0] value;
		logic              last;
	} layer_result_t;

	logic signed [15:0] weights [4096];
	logic signed [15:0] biases [64];
	logic signed [15:0] acts_in [64];
	logic signed [15:0] acts_out [64];
	logic signed [15:0] errs_out [64];
	logic [6:0]  n_in_reg, n_out_reg;
	logic [14:0] rate_reg;
	layer_result_t results_due [$];

	function automatic void queue_result(input layer_result_t r);
		results_due.insert(results_due.size(), r);
	endfunction

	function automatic logic signed [15:0] clip16(input longint v);
		if (v > 32767) return 16'sd32767;
		if (v < -32768) return -16'sd32768;
		return v[15:0];
	endfunction

	function automatic logic signed [15:0] squash(input logic signed [15:0] x);
		int a, y;
		a = (x < 0) ? -int'(x) : int'(x);
		if (a >= 20480) y = 4096;
		else if (a >= 9728) y = (a >> 5) + 3456;
		else if (a >= 4096) y = (a >> 3) + 2560;
		else y = (a >> 2) + 2048;
		return (x < 0) ? 16'(4096 - y) : 16'(y);
	endfunction

	function automatic int clamp_count(input logic [6:0] r);
		if (r == 0) return 1;
		return (r > 64) ? 64 : int'(r);
	endfunction

	task automatic run_layer(input logic [2:0] cmd, input logic [5:0] oi, input logic [5:0] ii,
			input logic signed [15:0] v);
		int ni, no;
		longint acc, a, d, f;
		layer_result_t r;
		ni = clamp_count(n_in_reg);
		no = clamp_count(n_out_reg);
		case (cmd)
			CMD_WEIGHT: weights[{oi, ii}] = v;
			CMD_BIAS:   biases[oi] = v;
			CMD_ACT:    acts_in[ii] = v;
			CMD_ERR:    errs_out[oi] = v;
			CMD_FORWARD: begin
				for (int o = 0; o < no; o++) begin
					acc = longint'(biases[o]) * 4096;
					for (int i = 0; i < ni; i++)
						acc += longint'(acts_in[i]) * longint'(weights[o * 64 + i]);
					acts_out[o] = squash(clip16(acc >>> 12));
					r.kind = KIND_ACT; r.index = o[5:0]; r.value = acts_out[o];
					r.last = (o + 1 == no);
					queue_result(r);
				end
			end
			CMD_BACKWARD: begin
				for (int i = 0; i < ni; i++) begin
					acc = 0;
					for (int o = 0; o < no; o++)
						acc += longint'(errs_out[o]) * longint'(weights[o * 64 + i]);
					r.kind = KIND_ERR; r.index = i[5:0]; r.value = clip16(acc >>> 12);
					r.last = (i + 1 == ni);
					queue_result(r);
				end
			end
			CMD_CORRECT: begin
				for (int o = 0; o < no; o++) begin
					a = longint'(acts_out[o]);
					d = (a * (4096 - a)) >>> 12;
					f = longint'(rate_reg) * longint'(errs_out[o]) * d;
					for (int i = 0; i < ni; i++)
						weights[o * 64 + i] = clip16(longint'(weights[o * 64 + i]) +
							((f * longint'(acts_in[i])) >>> 36));
				end
				r.kind = KIND_DONE; r.index = '0; r.value = '0; r.last = 1'b1;
				queue_result(r);
			end
			default: ;
		endcase
	endtask

	always @(posedge clk or negedge arst_n) begin
		layer_result_t want;
		if (!arst_n) begin
			results_due.delete();
			errors = 0;
			for (int k = 0; k < 64; k++) acts_out[k] = '0;
			n_in_reg = RST_INPUTS;
			n_out_reg = RST_OUTPUTS;
			rate_reg = RST_RATE;
		end else begin
			if (m_valid && m_ready) begin
				if (results_due.size() == 0) begin
					$error("result with nothing expected: kind %0d index %0d", m_user, m_data[5:0]);
					errors++;
				end else begin
					want = results_due.pop_front();
					if (m_user != want.kind) begin
						$error("kind: expected %0d, got %0d", want.kind, m_user); errors++;
					end
					if (m_data[5:0] != want.index) begin
						$error("index: expected %0d, got %0d", want.index, m_data[5:0]); errors++;
					end
					if ($signed(m_data[21:6]) != want.value) begin
						$error("result_value: expected %0d, got %0d", want.value,
							$signed(m_data[21:6]));
						errors++;
					end
					if (m_last != want.last) begin
						$error("last: expected %0d, got %0d", want.last, m_last); errors++;
					end
				end
			end
			if (cfg_valid && cfg_ready) begin
				case (cfg_index)
					REG_INPUTS:  n_in_reg = cfg_data[6:0];
					REG_OUTPUTS: n_out_reg = cfg_data[6:0];
					REG_RATE:    rate_reg = cfg_data;
					default: ;
				endcase
			end
			if (s_valid && s_ready)
				run_layer(s_user, s_data[5:0], s_data[11:6], s_data[27:12]);
		end
		pending = results_due.size();
	end
endmodule

// File: test/dense_layer_sigmoid_trainer_tb.sv
`timescale 1ns / 100ps
// Top of the dense layer trainer testbench: clock, reset, command and register stimulus.
// Instantiates dense_layer_sigmoid_trainer and dlst_checker; uses dlst_pkg.
module dense_layer_sigmoid_trainer_tb;
	import dlst_pkg::*;

	localparam int QUIET_LIMIT = 30000;
	localparam int SHAPE_MAX   = 4;
	localparam logic [2:0] CMD_UNKNOWN = 3'd7;
	localparam logic [1:0] REG_UNUSED  = 2'd3;

	logic        clk, arst_n;
	logic        s_axis_tvalid, s_axis_tready;
	logic [31:0] s_axis_tdata;
	logic [2:0]  s_axis_tuser;
	logic        m_axis_tvalid, m_axis_tready, m_axis_tlast;
	logic [23:0] m_axis_tdata;
	logic [1:0]  m_axis_tuser;
	logic        cfg_valid, cfg_ready;
	logic [1:0]  cfg_index;
	logic [14:0] cfg_data;
	int          errors, pending;
	int          burst_left;
	bit          squeeze;

	dense_layer_sigmoid_trainer dut (.*);

	dlst_checker chk (
		.clk, .arst_n,
		.s_valid(s_axis_tvalid), .s_ready(s_axis_tready), .s_data(s_axis_tdata),
		.s_user(s_axis_tuser),
		.m_valid(m_axis_tvalid), .m_ready(m_axis_tready), .m_data(m_axis_tdata),
		.m_user(m_axis_tuser), .m_last(m_axis_tlast),
		.cfg_valid, .cfg_ready, .cfg_index, .cfg_data,
		.errors, .pending
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	task automatic send_cmd(input logic [2:0] cmd, input logic [5:0] oi, input logic [5:0] ii,
			input logic [15:0] v);
		if (burst_left == 0) begin
			s_axis_tvalid <= 1'b0;
			repeat ($urandom_range(1, 6)) @(negedge clk);
			burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(20, 60) : $urandom_range(0, 8);
		end else begin
			burst_left--;
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tuser <= cmd;
		s_axis_tdata <= {4'b0, v, ii, oi};
		do @(posedge clk); while (!s_axis_tready);
		@(negedge clk);
	endtask

	task automatic write_reg(input logic [1:0] idx, input logic [14:0] data);
		s_axis_tvalid <= 1'b0;
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= data;
		do @(posedge clk); while (!cfg_ready);
		@(negedge clk);
		cfg_valid <= 1'b0;
	endtask

	// hold until every result is in, then let any trailing load settle
	task automatic wait_idle();
		s_axis_tvalid <= 1'b0;
		@(negedge clk);
		while (pending != 0) @(negedge clk);
		repeat (20) @(negedge clk);
	endtask

	function automatic logic [15:0] rand_value();
		if ($urandom_range(0, 2) == 0) return 16'($urandom);
		return 16'($urandom_range(0, 8192) - 4096);
	endfunction

	task automatic set_shape(input int ni, input int no, input logic [14:0] rate);
		write_reg(REG_INPUTS, {8'($urandom), 7'(ni)});
		write_reg(REG_OUTPUTS, {8'($urandom), 7'(no)});
		write_reg(REG_RATE, rate);
	endtask

	task automatic random_item();
		int pick;
		pick = $urandom_range(0, 99);
		if (pick < 55)
			send_cmd(3'($urandom_range(CMD_WEIGHT, CMD_ERR)), 6'($urandom_range(0, SHAPE_MAX - 1)),
				6'($urandom_range(0, SHAPE_MAX - 1)), rand_value());
		else if (pick < 72) send_cmd(CMD_FORWARD, 6'($urandom), 6'($urandom), 16'($urandom));
		else if (pick < 85) send_cmd(CMD_BACKWARD, 6'($urandom), 6'($urandom), 16'($urandom));
		else if (pick < 97) send_cmd(CMD_CORRECT, 6'($urandom), 6'($urandom), 16'($urandom));
		else send_cmd(CMD_UNKNOWN, 6'($urandom), 6'($urandom), 16'($urandom));
	endtask

	// receiver: switch stall patterns now and then, with one long hold-off on request
	initial begin
		int mode, span;
		m_axis_tready = 1'b0;
		mode = 0;
		span = 0;
		@(posedge arst_n);
		forever begin
			@(negedge clk);
			if (squeeze) begin
				m_axis_tready <= 1'b0;
				repeat (3000) @(negedge clk);
				squeeze = 1'b0;
			end else begin
				if (span == 0) begin
					mode = $urandom_range(0, 2);
					span = $urandom_range(10, 120);
				end
				span--;
				case (mode)
					0: m_axis_tready <= 1'b1;
					1: m_axis_tready <= 1'($urandom_range(0, 1));
					default: m_axis_tready <= ($urandom_range(0, 3) == 0);
				endcase
			end
		end
	end

	// watchdog: count cycles with no transaction on any channel
	initial begin
		int quiet;
		quiet = 0;
		while (quiet < QUIET_LIMIT) begin
			@(posedge clk);
			if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) ||
					(cfg_valid && cfg_ready) || !arst_n)
				quiet = 0;
			else
				quiet++;
		end
		$display("CHECK FAILED");
		$finish;
	end

	initial begin
		int ni, no;
		arst_n = 1'b0;
		s_axis_tvalid = 1'b0;
		s_axis_tdata = '0;
		s_axis_tuser = '0;
		cfg_valid = 1'b0;
		cfg_index = '0;
		cfg_data = '0;
		squeeze = 1'b0;
		burst_left = 0;
		repeat (4) @(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		// keep every pass inside a small corner of the stores, filled before any pass runs
		write_reg(REG_INPUTS, 15'(SHAPE_MAX));
		write_reg(REG_OUTPUTS, 15'(SHAPE_MAX));
		for (int o = 0; o < SHAPE_MAX; o++)
			for (int i = 0; i < SHAPE_MAX; i++)
				send_cmd(CMD_WEIGHT, 6'(o), 6'(i), 16'($urandom));
		for (int k = 0; k < SHAPE_MAX; k++) begin
			send_cmd(CMD_BIAS, 6'(k), 6'($urandom), 16'($urandom));
			send_cmd(CMD_ACT, 6'($urandom), 6'(k), 16'($urandom));
			send_cmd(CMD_ERR, 6'(k), 6'($urandom), 16'($urandom));
		end

		// correct before any forward pass sees all-zero output activations
		send_cmd(CMD_CORRECT, '0, '0, '0);
		send_cmd(CMD_WEIGHT, 6'd0, 6'd0, 16'h7fff);
		send_cmd(CMD_WEIGHT, 6'(SHAPE_MAX - 1), 6'(SHAPE_MAX - 1), 16'h8000);
		send_cmd(CMD_BIAS, 6'd0, 6'd0, 16'h8000);
		send_cmd(CMD_BIAS, 6'(SHAPE_MAX - 1), 6'd63, 16'h7fff);
		send_cmd(CMD_ACT, 6'd0, 6'd0, 16'h7fff);
		send_cmd(CMD_ACT, 6'd63, 6'(SHAPE_MAX - 1), 16'h8000);
		send_cmd(CMD_ERR, 6'd0, 6'd0, 16'h8000);
		send_cmd(CMD_ERR, 6'(SHAPE_MAX - 1), 6'd63, 16'h7fff);
		send_cmd(CMD_UNKNOWN, 6'd63, 6'd63, 16'hffff);
		send_cmd(CMD_FORWARD, '0, '0, '0);
		send_cmd(CMD_BACKWARD, '0, '0, '0);
		send_cmd(CMD_CORRECT, '0, '0, '0);
		send_cmd(CMD_FORWARD, '0, '0, '0);
		wait_idle();

		// zero count acts as one
		set_shape(0, 0, 15'h7fff);
		write_reg(REG_UNUSED, 15'h7fff);
		send_cmd(CMD_FORWARD, '0, '0, '0);
		send_cmd(CMD_BACKWARD, '0, '0, '0);
		send_cmd(CMD_CORRECT, '0, '0, '0);
		wait_idle();
		set_shape(SHAPE_MAX, 1, 15'd0);
		send_cmd(CMD_FORWARD, '0, '0, '0);
		send_cmd(CMD_CORRECT, '0, '0, '0);
		send_cmd(CMD_BACKWARD, '0, '0, '0);
		wait_idle();

		// fill the result path while the receiver holds off
		set_shape(2, SHAPE_MAX, 15'($urandom));
		squeeze = 1'b1;
		repeat (4) send_cmd(CMD_FORWARD, '0, '0, '0);
		wait_idle();

		for (int phase = 0; phase < 6; phase++) begin
			ni = $urandom_range(0, SHAPE_MAX);
			no = $urandom_range(0, SHAPE_MAX);
			set_shape(ni, no, 15'($urandom));
			repeat (15) random_item();
			wait_idle();
		end

		repeat (50) @(negedge clk);
		if (errors == 0 && pending == 0)
			$display("CHECK OK");
		else
			$display("CHECK FAILED");
		$finish;
	end
endmodule

// File: dense_layer_sigmoid_trainer.f
design/dlst_pkg.sv
design/dlst_ram.sv
design/dlst_ctrl.sv
design/dlst_dp.sv
design/dense_layer_sigmoid_trainer.sv
test/dlst_checker.sv
test/dense_layer_sigmoid_trainer_tb.sv
